@@ sv/ihc_pkg.sv @@
// ihc_pkg: types, constants and protocol tables for the IP header classifier.
// Depends on nothing; used by every module of the block.
package ihc_pkg;

	localparam int LenBitsDefault = 17;

	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  ip_version;
		logic [7:0]  upper_protocol;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
		logic        tunneled;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MAL  = 2'd1,
		ST_UNK  = 2'd2,
		ST_FRAG = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_START = 3'd0,
		PH_V4    = 3'd1,
		PH_V6    = 3'd2,
		PH_EXT0  = 3'd3,
		PH_EXT1  = 3'd4,
		PH_SKIP  = 3'd5,
		PH_DRAIN = 3'd6
	} phase_t;

	localparam logic [7:0] PrHopopts  = 8'd0;
	localparam logic [7:0] PrIgmp     = 8'd2;
	localparam logic [7:0] PrIpv6     = 8'd41;
	localparam logic [7:0] PrFragment = 8'd44;
	localparam logic [7:0] PrDsr      = 8'd48;

	function automatic logic known_v4(input logic [7:0] p);
		case (p)
			8'd1, 8'd2, 8'd6, 8'd17, 8'd41, 8'd47, 8'd48, 8'd50,
			8'd51, 8'd88, 8'd89, 8'd103, 8'd112, 8'd115, 8'd132: known_v4 = 1'b1;
			default: known_v4 = 1'b0;
		endcase
	endfunction

	function automatic logic known_v6(input logic [7:0] p);
		case (p)
			8'd1, 8'd2, 8'd6, 8'd17, 8'd47, 8'd48, 8'd50, 8'd51,
			8'd58, 8'd88, 8'd103, 8'd112, 8'd132: known_v6 = 1'b1;
			default: known_v6 = 1'b0;
		endcase
	endfunction

	// Minimum-length rule for IGMP and DSR payloads.
	function automatic status_t upper_check(input logic [7:0] p, input logic [16:0] len);
		if (p == PrIgmp && len < 17'd8) upper_check = ST_MAL;
		else if (p == PrDsr && len < 17'd4) upper_check = ST_MAL;
		else upper_check = ST_OK;
	endfunction

endpackage

@@ sv/ihc_parser.sv @@
// ihc_parser: per-byte header state and the end-of-frame verdict.
// Depends on ihc_pkg. Takes one registered byte a cycle while en is high, gives a result
// strobe combinationally from the state and that byte.
module ihc_parser #(
	parameter int LEN_BITS = ihc_pkg::LenBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  ihc_pkg::in_beat_t   beat,
	output logic                res_valid,
	output ihc_pkg::out_beat_t  res
);
	import ihc_pkg::*;

	localparam logic [LEN_BITS-1:0] CountMax = '1;

	logic [LEN_BITS-1:0] byte_count_q;
	phase_t              phase_q;
	logic [16:0]         csum_q;
	logic [7:0]          hlen_q;
	logic [15:0]         tlen_q;
	logic [7:0]          nproto_q;
	logic [15:0]         rem_q;
	logic [10:0]         ext_left_q;
	status_t             verdict_q;
	logic [13:0]         frag_q;
	logic                kind_q;
	logic [3:0]          ver_out_q, ver_in_q;
	logic [7:0]          v4p_q;
	logic [15:0]         plen_q;
	logic [15:0]         payoff_q;
	logic                wdone_q;

	logic [LEN_BITS-1:0] byte_count_d;
	phase_t              phase_d;
	logic [16:0]         csum_d;
	logic [7:0]          hlen_d;
	logic [15:0]         tlen_d;
	logic [7:0]          nproto_d;
	logic [15:0]         rem_d;
	logic [10:0]         ext_left_d;
	status_t             verdict_d;
	logic [13:0]         frag_d;
	logic                kind_d;
	logic [3:0]          ver_out_d, ver_in_d;
	logic [7:0]          v4p_d;
	logic [15:0]         plen_d;
	logic [15:0]         payoff_d;
	logic                wdone_d;

	logic [LEN_BITS:0]   pw;     // position, one bit wider for offset sums
	logic [LEN_BITS:0]   h6;
	logic [16:0]         csum_t;
	logic [11:0]         ext_size;
	logic [16:0]         v4_end;
	logic [7:0]          b;

	assign b = beat.data_byte;
	assign pw = {1'b0, byte_count_q};

	// Byte position clipped to the sixteen-bit offset field.
	function automatic logic [15:0] sat16(input logic [LEN_BITS:0] v);
		sat16 = (v > (LEN_BITS+1)'(16'hFFFF)) ? 16'hFFFF : v[15:0];
	endfunction

	always_comb begin
		phase_t ph;
		logic   do_res;
		byte_count_d = (byte_count_q < CountMax) ? byte_count_q + 1'b1 : byte_count_q;
		phase_d = phase_q; csum_d = csum_q; hlen_d = hlen_q; tlen_d = tlen_q;
		nproto_d = nproto_q; rem_d = rem_q; ext_left_d = ext_left_q;
		verdict_d = verdict_q; frag_d = frag_q; kind_d = kind_q;
		ver_out_d = ver_out_q; ver_in_d = ver_in_q; v4p_d = v4p_q;
		plen_d = plen_q; payoff_d = payoff_q; wdone_d = wdone_q;
		csum_t = '0; ext_size = '0; v4_end = '0; h6 = '0; do_res = 1'b0;
		ph = phase_q;
		if (phase_q == PH_START) begin
			kind_d = beat.func;
			ph = beat.func ? PH_V6 : PH_V4;
			phase_d = ph;
		end
		unique case (ph)
			PH_V4: begin
				if (pw == '0) begin
					ver_out_d = b[7:4];
					hlen_d = {2'b00, b[3:0], 2'b00};
				end else if (pw == (LEN_BITS+1)'(2)) tlen_d = {b, tlen_q[7:0]} & 16'hFF00;
				else if (pw == (LEN_BITS+1)'(3)) tlen_d = tlen_q | {8'h00, b};
				else if (pw == (LEN_BITS+1)'(6)) frag_d = {b[5:0], 8'h00};
				else if (pw == (LEN_BITS+1)'(7)) frag_d = frag_q | {6'd0, b};
				else if (pw == (LEN_BITS+1)'(9)) v4p_d = b;
				if (pw < (LEN_BITS+1)'(hlen_d)) begin
					csum_t = csum_q + (pw[0] ? {9'd0, b} : {1'b0, b, 8'h00});
					csum_d = csum_t[16] ? {1'b0, csum_t[15:0]} + 17'd1 : csum_t;
				end
				v4_end = (hlen_d >= 8'd20) ? {9'd0, hlen_d} : 17'd20;
				if (pw + 1'b1 == (LEN_BITS+1)'(v4_end))
					phase_d = (hlen_d >= 8'd20 && v4p_d == PrIpv6) ? PH_V6 : PH_DRAIN;
			end
			PH_V6: begin
				h6 = pw - (kind_d ? '0 : (LEN_BITS+1)'(hlen_q));
				if (h6 == '0) ver_in_d = b[7:4];
				else if (h6 == (LEN_BITS+1)'(4)) plen_d = {b, 8'h00};
				else if (h6 == (LEN_BITS+1)'(5)) plen_d = plen_q | {8'h00, b};
				else if (h6 == (LEN_BITS+1)'(6)) nproto_d = b;
				if (h6 == (LEN_BITS+1)'(39)) begin
					rem_d = plen_q;
					do_res = 1'b1;
				end else if (h6 > (LEN_BITS+1)'(39)) phase_d = PH_DRAIN;
			end
			PH_EXT0: begin
				nproto_d = b;
				phase_d = PH_EXT1;
			end
			PH_EXT1: begin
				ext_size = {1'b0, b, 3'b000} + 12'd8;
				if ({4'd0, rem_q} < {8'd0, ext_size}) begin
					verdict_d = ST_MAL; wdone_d = 1'b1;
					payoff_d = sat16({1'b0, byte_count_d}); phase_d = PH_DRAIN;
				end else begin
					rem_d = rem_q - {4'd0, ext_size};
					ext_left_d = 11'(ext_size - 12'd2);
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (ext_left_q != '0) ext_left_d = ext_left_q - 1'b1;
				if (ext_left_d == '0) do_res = 1'b1;
			end
			default: ;
		endcase
		// Resolve the next header after the fixed header or an extension.
		if (do_res) begin
			if (nproto_d == PrHopopts && rem_d >= 16'd2) phase_d = PH_EXT0;
			else begin
				wdone_d = 1'b1;
				payoff_d = sat16({1'b0, byte_count_d});
				phase_d = PH_DRAIN;
				if (nproto_d == PrHopopts) verdict_d = ST_MAL;
				else if (nproto_d == PrFragment)
					verdict_d = (rem_d < 16'd8) ? ST_MAL : ST_FRAG;
				else if (!known_v6(nproto_d)) verdict_d = ST_UNK;
				else verdict_d = upper_check(nproto_d, {1'b0, rem_d});
			end
		end
	end

	// Final verdict from the updated state.
	always_comb begin
		logic [LEN_BITS-1:0] len;
		logic [16:0]         nlen;
		logic [LEN_BITS:0]   l6;
		logic                v6;
		res = '0;
		len = byte_count_d;
		nlen = {1'b0, tlen_d} - {9'd0, hlen_d};
		l6 = '0; v6 = 1'b0;
		res_valid = en && beat.last_byte;
		if (!kind_d) begin
			res.ip_version = ver_out_d;
			if (len < LEN_BITS'(20) || hlen_d < 8'd20 || len < LEN_BITS'(hlen_d)
			    || csum_d != 17'h0FFFF) res.status = ST_MAL;
			else if (ver_out_d != 4'd4) res.status = ST_UNK;
			else if ({1'b0, len} < (LEN_BITS+1)'(tlen_d) || tlen_d < {8'd0, hlen_d})
				res.status = ST_MAL;
			else if (frag_d != '0) begin
				res.status = ST_FRAG; res.upper_protocol = v4p_d;
				res.payload_offset = {8'd0, hlen_d}; res.payload_length = nlen[15:0];
			end else if (v4p_d == PrIpv6) begin
				res.tunneled = 1'b1; res.ip_version = ver_in_d;
				l6 = (LEN_BITS+1)'(nlen); v6 = 1'b1;
			end else if (!known_v4(v4p_d)) begin
				res.status = ST_UNK; res.upper_protocol = v4p_d;
				res.payload_offset = {8'd0, hlen_d}; res.payload_length = nlen[15:0];
			end else begin
				res.status = upper_check(v4p_d, nlen);
				if (res.status == ST_OK) begin
					res.upper_protocol = v4p_d;
					res.payload_offset = {8'd0, hlen_d}; res.payload_length = nlen[15:0];
				end
			end
		end else begin
			res.ip_version = ver_in_d;
			l6 = {1'b0, len}; v6 = 1'b1;
		end
		if (v6) begin
			if (l6 < (LEN_BITS+1)'(40)) res.status = ST_MAL;
			else if (ver_in_d != 4'd6) res.status = ST_UNK;
			else if ({1'b0, l6} < (LEN_BITS+2)'(plen_d) + (LEN_BITS+2)'(40) || !wdone_d)
				res.status = ST_MAL;
			else begin
				res.status = verdict_d;
				if (verdict_d != ST_MAL) begin
					res.upper_protocol = nproto_d; res.payload_offset = payoff_d;
					res.payload_length = rem_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0; phase_q <= PH_START; csum_q <= '0; hlen_q <= '0;
			tlen_q <= '0; nproto_q <= '0; rem_q <= '0; ext_left_q <= '0;
			verdict_q <= ST_OK; frag_q <= '0; kind_q <= 1'b0; ver_out_q <= '0;
			ver_in_q <= '0; v4p_q <= '0; plen_q <= '0; payoff_q <= '0;
			wdone_q <= 1'b0;
		end else if (en && beat.last_byte) begin
			byte_count_q <= '0; phase_q <= PH_START; csum_q <= '0; hlen_q <= '0;
			tlen_q <= '0; nproto_q <= '0; rem_q <= '0; ext_left_q <= '0;
			verdict_q <= ST_OK; frag_q <= '0; kind_q <= 1'b0; ver_out_q <= '0;
			ver_in_q <= '0; v4p_q <= '0; plen_q <= '0; payoff_q <= '0;
			wdone_q <= 1'b0;
		end else if (en) begin
			byte_count_q <= byte_count_d; phase_q <= phase_d; csum_q <= csum_d;
			hlen_q <= hlen_d; tlen_q <= tlen_d; nproto_q <= nproto_d; rem_q <= rem_d;
			ext_left_q <= ext_left_d; verdict_q <= verdict_d; frag_q <= frag_d;
			kind_q <= kind_d; ver_out_q <= ver_out_d; ver_in_q <= ver_in_d;
			v4p_q <= v4p_d; plen_q <= plen_d; payoff_q <= payoff_d; wdone_q <= wdone_d;
		end
	end

`ifndef SYNTHESIS
	a_start_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		en && beat.last_byte |=> phase_q == PH_START && byte_count_q == '0)
		else $error("parser not cleared after last byte");
	a_csum_range: assert property (@(posedge clk) disable iff (!arst_n)
		csum_q[16] == 1'b0) else $error("checksum carry not folded");
	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> ext_left_q != '0) else $error("skip with zero count");
`endif

endmodule

@@ sv/ip_header_classifier.sv @@
// ip_header_classifier: top level, input register, parser and result register.
// Depends on ihc_pkg and ihc_parser.
// The result of a frame passes the input register, the parser and the result register.
// Throughput: one byte a cycle while in_stall is low; the input and the result register each hold a beat.
// Input stalls only while a result waits in the output register and the input
// register holds a last byte, so the parser never loses a result.
// Reset (arst_n low, asynchronous) clears all control state and the parse.
module ip_header_classifier #(
	parameter int LEN_BITS = ihc_pkg::LenBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ihc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ihc_pkg::out_beat_t out_data
);
	import ihc_pkg::*;

	// Input stage: one byte held for the parser.
	logic       v_s1;
	in_beat_t   d_s1;
	logic       adv;       // the parser consumes the byte held in stage one
	logic       res_valid;
	out_beat_t  res;

	// A byte that ends a frame can only move on when the result register is free;
	// other bytes produce no result and always move on.
	assign adv = v_s1 && !(d_s1.last_byte && out_valid && out_stall);
	assign in_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			d_s1 <= in_data;
		end
	end

	ihc_parser #(.LEN_BITS(LEN_BITS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.beat      (d_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data <= res;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(out_valid && out_stall)) else $error("result overwritten");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> d_s1.last_byte && out_valid) else $error("needless stall");
`endif

endmodule
